>>> rtl/core/rfeu_pkg.sv
// ----------------------------------------------------------------------------
// rfeu_pkg: register file execute unit shared definitions
// Opcodes, status codes, ecall numbers and register store geometry.
// ----------------------------------------------------------------------------
package rfeu_pkg;

	localparam int unsigned REG_COUNT = 1 << 16;
	localparam int unsigned IDX_W     = $clog2(REG_COUNT);
	localparam int unsigned DATA_W    = 64;

	typedef logic [5:0] opcode_t;
	localparam opcode_t OP_ADD   = 6'd13;
	localparam opcode_t OP_SUB   = 6'd14;
	localparam opcode_t OP_ADDI  = 6'd15;
	localparam opcode_t OP_SLT   = 6'd16;
	localparam opcode_t OP_SLTI  = 6'd17;
	localparam opcode_t OP_AND   = 6'd20;
	localparam opcode_t OP_ANDI  = 6'd21;
	localparam opcode_t OP_OR    = 6'd22;
	localparam opcode_t OP_ORI   = 6'd23;
	localparam opcode_t OP_XOR   = 6'd24;
	localparam opcode_t OP_XORI  = 6'd25;
	localparam opcode_t OP_SLL   = 6'd26;
	localparam opcode_t OP_SLLI  = 6'd27;
	localparam opcode_t OP_SRL   = 6'd28;
	localparam opcode_t OP_SRLI  = 6'd29;
	localparam opcode_t OP_BLT   = 6'd32;
	localparam opcode_t OP_BGE   = 6'd34;
	localparam opcode_t OP_BNE   = 6'd36;
	localparam opcode_t OP_BEQ   = 6'd37;
	localparam opcode_t OP_JAL   = 6'd38;
	localparam opcode_t OP_JALR  = 6'd39;
	localparam opcode_t OP_ECALL = 6'd41;
	localparam opcode_t OP_MUL   = 6'd53;
	localparam opcode_t OP_DIV   = 6'd57;
	localparam opcode_t OP_REM   = 6'd59;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BADOP    = 2'd1;
	localparam status_t ST_BADECALL = 2'd2;
	localparam status_t ST_RANGE    = 2'd3;

	localparam logic [63:0] ECALL_HALT  = 64'd1;
	localparam logic [63:0] ECALL_DEBUG = 64'd2;

	typedef enum logic [1:0] {
		MD_MUL,
		MD_DIV,
		MD_REM
	} md_op_t;

endpackage

>>> rtl/core/rfeu_ram.sv
// ----------------------------------------------------------------------------
// rfeu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfeu_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rfeu_muldiv.sv
// ----------------------------------------------------------------------------
// rfeu_muldiv: iterative multiply / divide unit
// Shift-add multiply and restoring divide, one bit per cycle, 64 steps.
// ----------------------------------------------------------------------------
module rfeu_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rfeu_pkg::md_op_t    mode,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         result
);
	import rfeu_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	md_op_t      mode_q;
	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [63:0] mplier_q;

	logic [64:0] partial;
	logic [65:0] diff;
	logic        ge;

	// divide: acc holds the partial remainder, mplier shifts dividend out, quotient in
	assign partial = {acc_q, mplier_q[63]};
	assign diff    = {1'b0, partial} - {2'b00, mcand_q};
	assign ge      = !diff[65];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q   <= mode;
			acc_q    <= '0;
			mcand_q  <= (mode == MD_MUL) ? a : b;
			mplier_q <= (mode == MD_MUL) ? b : a;
		end else if (run_q) begin
			if (mode_q == MD_MUL) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[62:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[63:1]};
			end else begin
				acc_q    <= ge ? diff[63:0] : partial[63:0];
				mplier_q <= {mplier_q[62:0], ge};
			end
		end
	end

	assign done = done_q;

	always_comb begin
		case (mode_q)
			MD_MUL:  result = acc_q;
			MD_DIV:  result = mplier_q;
			MD_REM:  result = acc_q;
			default: result = acc_q;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("muldiv done held");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && $past(run_q))
		else $error("muldiv done without run");

endmodule

>>> rtl/core/register_file_execute_unit.sv
// ----------------------------------------------------------------------------
// register_file_execute_unit: integer execute unit on a 64-bit register store
// Runs one instruction per transfer against a 64K x 64 register store.
//
//  channel   direction  handshake              payload
//  command   in         start && !busy         opcode, first_arg, second_arg,
//                                              third_arg, position
//  result    out        done (one cycle)       jump_taken, jump_target, halt,
//                                              debug_valid, debug_value, status
//
// Errors and ecall halt finish in the check state; other ops read their
// operands in turn (jal/jalr write the link first), then execute; mul, div and
// rem then run on the shared bit-serial unit. The store has one read and one
// write port with registered read; reads are issued one per cycle.
// After reset a clearing pass zeroes all 65536 entries of the store; busy is high.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module register_file_execute_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [5:0]           opcode,
	input  logic [63:0]          first_arg,
	input  logic [63:0]          second_arg,
	input  logic [63:0]          third_arg,
	input  logic [31:0]          position,
	output logic                 done,
	output logic                 jump_taken,
	output logic [63:0]          jump_target,
	output logic                 halt,
	output logic                 debug_valid,
	output logic [63:0]          debug_value,
	output rfeu_pkg::status_t    status
);
	import rfeu_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_LINK,
		S_RX,
		S_RY,
		S_RZ,
		S_EXEC,
		S_MD
	} state_t;

	state_t       state_q;
	logic [IDX_W-1:0] clr_q;
	opcode_t      op_q;
	logic [63:0]  a_q, b_q, c_q;
	logic [31:0]  pos_q;
	logic [63:0]  x_q, y_q, z_q;
	logic         done_q;
	logic         jt_q, halt_q, dv_q;
	logic [63:0]  tgt_q, dval_q;
	status_t      st_q;

	// decode
	logic is_imm, is_reg, is_alu, is_br, is_jal, is_md;
	logic oor_a, oor_b, oor_c;
	status_t chk_st;
	md_op_t md_mode;

	always_comb begin
		is_imm = (op_q == OP_ADDI) || (op_q == OP_SLTI) || (op_q == OP_ANDI) ||
			(op_q == OP_ORI) || (op_q == OP_XORI) || (op_q == OP_SLLI) ||
			(op_q == OP_SRLI);
		is_reg = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_SLT) ||
			(op_q == OP_AND) || (op_q == OP_OR) || (op_q == OP_XOR) ||
			(op_q == OP_SLL) || (op_q == OP_SRL) || (op_q == OP_MUL) ||
			(op_q == OP_DIV) || (op_q == OP_REM);
		is_alu = is_imm || is_reg;
		is_br  = (op_q == OP_BLT) || (op_q == OP_BGE) || (op_q == OP_BNE) ||
			(op_q == OP_BEQ);
		is_jal = (op_q == OP_JAL) || (op_q == OP_JALR);
		is_md  = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_REM);
		oor_a  = |a_q[63:IDX_W];
		oor_b  = |b_q[63:IDX_W];
		oor_c  = |c_q[63:IDX_W];

		chk_st = ST_OK;
		if (is_alu) begin
			if (oor_a || oor_b || (is_reg && oor_c)) chk_st = ST_RANGE;
		end else if (is_br) begin
			if (oor_a || oor_b || oor_c) chk_st = ST_RANGE;
		end else if (is_jal) begin
			if (oor_a || oor_b) chk_st = ST_RANGE;
		end else if (op_q == OP_ECALL) begin
			if (a_q == ECALL_DEBUG) begin
				if (oor_b) chk_st = ST_RANGE;
			end else if (a_q != ECALL_HALT) begin
				chk_st = ST_BADECALL;
			end
		end else begin
			chk_st = ST_BADOP;
		end

		case (op_q)
			OP_MUL:  md_mode = MD_MUL;
			OP_DIV:  md_mode = MD_DIV;
			default: md_mode = MD_REM;
		endcase
	end

	// register store
	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [63:0]      wdata, rdata;
	logic [63:0]      alu_res;
	logic             md_start, md_done;
	logic [63:0]      md_res;

	always_comb begin
		case (op_q)
			OP_ADD, OP_ADDI: alu_res = x_q + y_q;
			OP_SUB:          alu_res = x_q - y_q;
			OP_AND, OP_ANDI: alu_res = x_q & y_q;
			OP_OR, OP_ORI:   alu_res = x_q | y_q;
			OP_XOR, OP_XORI: alu_res = x_q ^ y_q;
			OP_SLT, OP_SLTI: alu_res = {63'd0, x_q < y_q};
			OP_SLL, OP_SLLI: alu_res = x_q << y_q[5:0];
			default:         alu_res = x_q >> y_q[5:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = a_q[IDX_W-1:0];
		wdata = alu_res;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_CHECK: begin
				we    = (chk_st == ST_OK) && is_jal;
				wdata = {32'd0, pos_q};
			end
			S_EXEC: we = is_alu && !is_md;
			S_MD: begin
				we    = md_done;
				wdata = md_res;
			end
			default: we = 1'b0;
		endcase

		case (state_q)
			S_CHECK: raddr = is_br ? a_q[IDX_W-1:0] : b_q[IDX_W-1:0];
			S_LINK:  raddr = b_q[IDX_W-1:0];
			S_RX:    raddr = is_br ? b_q[IDX_W-1:0] : c_q[IDX_W-1:0];
			default: raddr = c_q[IDX_W-1:0];
		endcase
	end

	assign md_start = (state_q == S_EXEC) && is_md;

	rfeu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(REG_COUNT)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	rfeu_muldiv u_md (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.mode  (md_mode),
		.a     (x_q),
		.b     (y_q),
		.done  (md_done),
		.result(md_res)
	);

	logic take;
	always_comb begin
		case (op_q)
			OP_BLT:  take = x_q < y_q;
			OP_BGE:  take = x_q >= y_q;
			OP_BNE:  take = x_q != y_q;
			default: take = x_q == y_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			jt_q    <= 1'b0;
			halt_q  <= 1'b0;
			dv_q    <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_CHECK;
				end
				S_CHECK: begin
					jt_q   <= 1'b0;
					halt_q <= 1'b0;
					dv_q   <= 1'b0;
					st_q   <= chk_st;
					if (chk_st != ST_OK) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (op_q == OP_ECALL && a_q == ECALL_HALT) begin
						halt_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (is_jal) begin
						state_q <= S_LINK;
					end else begin
						state_q <= S_RX;
					end
				end
				S_LINK: state_q <= S_RX;
				S_RX: begin
					if (is_br || is_reg) state_q <= S_RY;
					else state_q <= S_EXEC;
				end
				S_RY: state_q <= is_br ? S_RZ : S_EXEC;
				S_RZ: state_q <= S_EXEC;
				S_EXEC: begin
					if (is_md) begin
						state_q <= S_MD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (is_br) begin
							jt_q <= take && (z_q != '0);
						end else if (op_q == OP_JAL) begin
							jt_q <= x_q != '0;
						end else if (op_q == OP_JALR) begin
							jt_q <= 1'b1;
						end else if (op_q == OP_ECALL) begin
							dv_q <= 1'b1;
						end
					end
				end
				S_MD: begin
					if (md_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= opcode;
			a_q   <= first_arg;
			b_q   <= second_arg;
			c_q   <= third_arg;
			pos_q <= position;
		end
		case (state_q)
			S_CHECK: begin
				tgt_q  <= '0;
				dval_q <= '0;
			end
			S_RX: begin
				x_q <= rdata;
				if (is_imm) y_q <= c_q;
			end
			S_RY: y_q <= rdata;
			S_RZ: z_q <= rdata;
			S_EXEC: begin
				if (is_br) begin
					tgt_q <= (take && (z_q != '0)) ? z_q : '0;
				end else if (op_q == OP_JAL) begin
					tgt_q <= x_q;
				end else if (op_q == OP_JALR) begin
					tgt_q <= x_q + c_q;
				end else if (op_q == OP_ECALL) begin
					dval_q <= x_q;
				end
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign jump_taken  = jt_q;
	assign jump_target = tgt_q;
	assign halt        = halt_q;
	assign debug_valid = dv_q;
	assign debug_value = dval_q;
	assign status      = st_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> !jump_taken && !halt && !debug_valid)
		else $error("error result with side outputs");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we)
		else $error("store written while idle");

endmodule
